// File: hw/rtl/tmcc_pkg.sv
// shared types and constants for the trimmed-mean conductivity converter
// no dependencies
package tmcc_pkg;

    localparam int WINDOW_SIZE_DEF = 32;
    localparam int TRIM            = 5;
    localparam int OUT_W           = 17;
    localparam int V_W             = 20;
    localparam int DVD_W           = 48;
    localparam int DSR_W           = 24;
    localparam int MUL_W           = 28;
    localparam int ACC_W           = 64;

    localparam logic [OUT_W-1:0] OUT_MAX = 17'h1FFFF;
    localparam logic [23:0] COEF_A = 24'd4835705;
    localparam logic [26:0] COEF_B = 27'd39863583;
    localparam logic [23:0] COEF_C = 24'd887030;

    localparam logic [23:0] VPB_RST  = 24'd805306;
    localparam logic [15:0] TDSF_RST = 16'd32768;
    localparam logic [15:0] SALF_RST = 16'd36045;
    localparam logic [15:0] HDIV_RST = 16'd4378;

    typedef enum logic [1:0] {
        REG_VPB  = 2'd0,
        REG_TDSF = 2'd1,
        REG_SALF = 2'd2,
        REG_HDIV = 2'd3
    } t_reg;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_WRITE,
        OP_LOAD,
        OP_LATCH,
        OP_CMP,
        OP_ACC,
        OP_MUL_V,
        OP_DIV_V,
        OP_SAT_V,
        OP_MUL_T,
        OP_DIV_T,
        OP_SAT_T,
        OP_SQ,
        OP_PA,
        OP_PB,
        OP_PC,
        OP_PD,
        OP_EC,
        OP_TDS,
        OP_SAL,
        OP_DIV_H,
        OP_HARD,
        OP_OUT
    } t_op;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic out_full;
    } t_status;

endpackage

// File: hw/rtl/trimmed_mean_conductivity_converter.sv
// Trimmed-mean conductivity converter. Each accepted request stores one ADC
// sample into a WINDOW_SIZE-entry ring window (zero after reset), ranks every
// window entry against all others, averages all but the 5 lowest and 5 highest,
// converts to volts, compensates for temperature and produces EC, TDS, salinity
// and hardness in 1/16 units. One request at a time: a ranking pass, paced by
// the single read port of the window memory, then two 48-step serial divisions
// and the multiply steps. A finished result waits in an output register while
// the next request is taken.
// depends on tmcc_pkg, tmcc_ctrl, tmcc_dpath
module trimmed_mean_conductivity_converter
    import tmcc_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // adc_sample[15:0], temperature[27:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,   // conductivity[16:0], dissolved_solids[33:17],
                                        // salinity[50:34], hardness[67:51]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = $clog2(WINDOW_SIZE);

    logic [23:0] r_vpb;
    logic [15:0] r_tdsf, r_salf, r_hdiv;
    t_reg        reg_sel;
    t_cmd        cmd;
    t_status     status;
    logic [IW-1:0] idx_i, idx_j;

    assign pready  = 1'b1;
    assign reg_sel = t_reg'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vpb  <= VPB_RST;
            r_tdsf <= TDSF_RST;
            r_salf <= SALF_RST;
            r_hdiv <= HDIV_RST;
        end else if (psel && penable && pwrite) begin
            unique case (reg_sel)
                REG_VPB:  r_vpb  <= pwdata[23:0];
                REG_TDSF: r_tdsf <= pwdata[15:0];
                REG_SALF: r_salf <= pwdata[15:0];
                REG_HDIV: r_hdiv <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_sel)
            REG_VPB:  prdata = {8'h00, r_vpb};
            REG_TDSF: prdata = {16'h0000, r_tdsf};
            REG_SALF: prdata = {16'h0000, r_salf};
            REG_HDIV: prdata = {16'h0000, r_hdiv};
            default:  prdata = '0;
        endcase
    end

    tmcc_ctrl #(.WINDOW_SIZE(WINDOW_SIZE)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_s_valid(s_axis_tvalid),
        .o_s_ready(s_axis_tready),
        .o_cmd    (cmd),
        .o_idx_i  (idx_i),
        .o_idx_j  (idx_j),
        .i_status (status)
    );

    tmcc_dpath #(.WINDOW_SIZE(WINDOW_SIZE)) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_idx_i  (idx_i),
        .i_idx_j  (idx_j),
        .i_sample (s_axis_tdata[15:0]),
        .i_temp   (s_axis_tdata[27:16]),
        .i_vpb    (r_vpb),
        .i_tdsf   (r_tdsf),
        .i_salf   (r_salf),
        .i_hdiv   (r_hdiv),
        .o_status (status),
        .o_m_valid(m_axis_tvalid),
        .i_m_ready(m_axis_tready),
        .o_m_data (m_axis_tdata)
    );

endmodule

// File: hw/rtl/tmcc_ctrl.sv
// sequencer for the converter: rank loops, arithmetic steps, result hand-off
// depends on tmcc_pkg
module tmcc_ctrl
    import tmcc_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    localparam int IW = $clog2(WINDOW_SIZE)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_valid,
    output logic          o_s_ready,
    output t_cmd          o_cmd,
    output logic [IW-1:0] o_idx_i,
    output logic [IW-1:0] o_idx_j,
    input  t_status       i_status
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_LATCH, ST_CMP, ST_DRAIN, ST_ACC,
        ST_MUL_V, ST_DIV_V, ST_WAIT_V, ST_SAT_V,
        ST_MUL_T, ST_DIV_T, ST_WAIT_T, ST_SAT_T,
        ST_SQ, ST_PA, ST_PB, ST_PC, ST_PD, ST_EC,
        ST_TDS, ST_SAL, ST_DIV_H, ST_WAIT_H, ST_HARD, ST_OUT
    } t_state;

    localparam logic [IW-1:0] LAST = IW'(WINDOW_SIZE - 1);

    t_state        r_state, n_state;
    logic [IW-1:0] r_i, n_i, r_j, n_j;

    assign o_s_ready = (r_state == ST_IDLE);
    assign o_idx_i   = r_i;
    assign o_idx_j   = r_j;

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        o_cmd.op = OP_NONE;
        unique case (r_state)
            ST_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.op = OP_WRITE;
                    n_i      = '0;
                    n_state  = ST_LOAD;
                end
            end
            ST_LOAD: begin
                o_cmd.op = OP_LOAD;
                n_state  = ST_LATCH;
            end
            ST_LATCH: begin
                o_cmd.op = OP_LATCH;
                n_j      = '0;
                n_state  = ST_CMP;
            end
            ST_CMP: begin
                o_cmd.op = OP_CMP;
                n_j      = r_j + 1'b1;
                if (r_j == LAST) n_state = ST_DRAIN;
            end
            ST_DRAIN: n_state = ST_ACC;
            ST_ACC: begin
                o_cmd.op = OP_ACC;
                n_i      = r_i + 1'b1;
                n_state  = (r_i == LAST) ? ST_MUL_V : ST_LOAD;
            end
            ST_MUL_V: begin o_cmd.op = OP_MUL_V; n_state = ST_DIV_V; end
            ST_DIV_V: begin o_cmd.op = OP_DIV_V; n_state = ST_WAIT_V; end
            ST_WAIT_V: if (!i_status.div_busy) n_state = ST_SAT_V;
            ST_SAT_V: begin o_cmd.op = OP_SAT_V; n_state = ST_MUL_T; end
            ST_MUL_T: begin o_cmd.op = OP_MUL_T; n_state = ST_DIV_T; end
            ST_DIV_T: begin o_cmd.op = OP_DIV_T; n_state = ST_WAIT_T; end
            ST_WAIT_T: if (!i_status.div_busy) n_state = ST_SAT_T;
            ST_SAT_T: begin o_cmd.op = OP_SAT_T; n_state = ST_SQ; end
            ST_SQ: begin o_cmd.op = OP_SQ; n_state = ST_PA; end
            ST_PA: begin o_cmd.op = OP_PA; n_state = ST_PB; end
            ST_PB: begin o_cmd.op = OP_PB; n_state = ST_PC; end
            ST_PC: begin o_cmd.op = OP_PC; n_state = ST_PD; end
            ST_PD: begin o_cmd.op = OP_PD; n_state = ST_EC; end
            ST_EC: begin o_cmd.op = OP_EC; n_state = ST_TDS; end
            ST_TDS: begin o_cmd.op = OP_TDS; n_state = ST_SAL; end
            ST_SAL: begin o_cmd.op = OP_SAL; n_state = ST_DIV_H; end
            ST_DIV_H: begin o_cmd.op = OP_DIV_H; n_state = ST_WAIT_H; end
            ST_WAIT_H: if (!i_status.div_busy) n_state = ST_HARD;
            ST_HARD: begin o_cmd.op = OP_HARD; n_state = ST_OUT; end
            ST_OUT: begin
                // hold until the output register has room
                if (!i_status.out_full) begin
                    o_cmd.op = OP_OUT;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
        end
    end

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_valid && o_s_ready) |=> (r_state == ST_LOAD))
        else $error("no work started after request");
    a_out_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_OUT) |-> !i_status.out_full)
        else $error("result written over a pending one");
    a_div_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == OP_DIV_T || o_cmd.op == OP_DIV_H)
        |=> i_status.div_busy)
        else $error("divider did not start");
`endif

endmodule

// File: hw/rtl/tmcc_dpath.sv
// datapath: sample window memory, rank counter, shared multiplier,
// shared bit-serial divider, result register; depends on tmcc_pkg
module tmcc_dpath
    import tmcc_pkg::*;
#(
    parameter int WINDOW_SIZE = WINDOW_SIZE_DEF,
    localparam int IW = $clog2(WINDOW_SIZE)
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic [IW-1:0]     i_idx_i,
    input  logic [IW-1:0]     i_idx_j,
    input  logic signed [15:0] i_sample,
    input  logic signed [11:0] i_temp,
    input  logic [23:0]       i_vpb,
    input  logic [15:0]       i_tdsf,
    input  logic [15:0]       i_salf,
    input  logic [15:0]       i_hdiv,
    output t_status           o_status,
    output logic              o_m_valid,
    input  logic              i_m_ready,
    output logic [71:0]       o_m_data
);

    localparam int SW = 17 + IW;
    localparam logic [IW-1:0] LAST = IW'(WINDOW_SIZE - 1);
    localparam logic [IW-1:0] RK_LO = IW'(TRIM);
    localparam logic [IW-1:0] RK_HI = IW'(WINDOW_SIZE - 1 - TRIM);
    // division by the kept count: reciprocal multiply on the 2^16-scaled value,
    // numerator clamped where the quotient saturates anyway
    localparam int CNT = WINDOW_SIZE - 2 * TRIM;
    localparam int RSH = 26 + $clog2(CNT);
    localparam logic [27:0] RECIP =
        28'(((longint'(1) << RSH) + longint'(CNT) - 1) / longint'(CNT));
    localparam logic [25:0] N_CLAMP = 26'(524289 * CNT);

    // window memory with per-entry valid bits (invalid entries read zero)
    logic signed [15:0] mem [WINDOW_SIZE];
    logic [WINDOW_SIZE-1:0] r_vld;
    logic [IW-1:0]      r_wp;
    logic signed [15:0] r_rd, r_vi;
    logic [IW-1:0]      r_jd, rd_addr;
    logic               r_cv;
    logic [IW-1:0]      r_rank;
    logic signed [SW-1:0] r_sum;
    logic signed [11:0] r_temp;

    logic signed [MUL_W-1:0] mul_a, mul_b;
    logic signed [2*MUL_W-1:0] prod, r_prod;
    logic signed [V_W-1:0] r_x, r_xc;
    logic [39:0]        r_sq;
    logic signed [ACC_W-1:0] r_acc, acc_rnd;
    logic [OUT_W-1:0]   r_ec, r_tds, r_sal, r_hard;
    logic [33:0]        r_p;

    logic [DVD_W-1:0]   r_dvd, prod_mag;
    logic [DSR_W-1:0]   r_dsr, temp_dsr;
    logic [DSR_W:0]     r_rem, trial, diff;
    logic [5:0]         r_dcnt;
    logic               r_dbusy, r_dneg, div_start;
    logic signed [12:0] den;
    logic [25:0]        v_num;
    logic [53:0]        v_qprod;

    logic               r_ovalid;
    logic [71:0]        r_odata;
    logic               less;

    assign rd_addr = (i_cmd.op == OP_LOAD) ? i_idx_i : i_idx_j;

    always_ff @(posedge i_clk) begin
        if (i_cmd.op == OP_WRITE) mem[r_wp] <= i_sample;
        r_rd <= r_vld[rd_addr] ? mem[rd_addr] : 16'sd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_wp  <= '0;
        end else if (i_cmd.op == OP_WRITE) begin
            r_vld[r_wp] <= 1'b1;
            r_wp        <= (r_wp == LAST) ? '0 : r_wp + 1'b1;
        end
    end

    // stable rank: smaller value, or equal value at a lower slot
    assign less = (r_rd < r_vi) || ((r_rd == r_vi) && (r_jd < i_idx_i));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cv <= 1'b0;
        else          r_cv <= (i_cmd.op == OP_CMP);
        r_jd <= i_idx_j;
        if (i_cmd.op == OP_WRITE) begin
            r_temp <= i_temp;
            r_sum  <= '0;
        end
        if (i_cmd.op == OP_LATCH) begin
            r_vi   <= r_rd;
            r_rank <= '0;
        end else if (r_cv && less) begin
            r_rank <= r_rank + 1'b1;
        end
        if (i_cmd.op == OP_ACC && r_rank >= RK_LO && r_rank <= RK_HI)
            r_sum <= r_sum + SW'(r_vi);
    end

    // shared multiplier
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (i_cmd.op)
            OP_MUL_V: begin mul_a = MUL_W'(r_sum); mul_b = MUL_W'({1'b0, i_vpb}); end
            OP_MUL_T: begin mul_a = MUL_W'(r_x); mul_b = MUL_W'(800); end
            OP_SQ:    begin mul_a = MUL_W'(r_xc); mul_b = MUL_W'(r_xc); end
            OP_PA:    begin mul_a = MUL_W'({1'b0, COEF_A}); mul_b = MUL_W'({1'b0, r_sq[19:0]}); end
            OP_PB:    begin mul_a = MUL_W'({1'b0, COEF_A}); mul_b = MUL_W'({1'b0, r_sq[39:20]}); end
            OP_PC:    begin mul_a = MUL_W'({1'b0, COEF_B}); mul_b = MUL_W'(r_xc); end
            OP_TDS:   begin mul_a = MUL_W'({1'b0, r_ec}); mul_b = MUL_W'({1'b0, i_tdsf}); end
            OP_SAL:   begin mul_a = MUL_W'({1'b0, r_ec}); mul_b = MUL_W'({1'b0, i_salf}); end
            default: ;
        endcase
    end
    assign prod = mul_a * mul_b;

    function automatic logic signed [V_W-1:0] sat_v(input logic [DVD_W-1:0] mag,
                                                    input logic neg);
        logic signed [V_W-1:0] res;
        if (neg) begin
            if (mag > DVD_W'(524288)) res = -20'sd524288;
            else                      res = V_W'(-$signed({1'b0, mag}));
        end else begin
            if (mag > DVD_W'(524287)) res = 20'sd524287;
            else                      res = V_W'(mag);
        end
        return res;
    endfunction

    assign prod_mag = r_prod[2*MUL_W-1] ? DVD_W'(-r_prod) : DVD_W'(r_prod);
    assign v_num    = (prod_mag[DVD_W-1:16] > (DVD_W-16)'(N_CLAMP))
                      ? N_CLAMP : prod_mag[41:16];
    assign v_qprod  = v_num * RECIP;
    always_comb begin
        den = 13'(r_temp) + 13'sd400;
        if (den < 13'sd1) den = 13'sd1;
    end
    assign temp_dsr = DSR_W'(unsigned'(den));
    assign acc_rnd  = (r_acc + (ACC_W'(1) <<< 43)) >>> 44;
    assign div_start = (i_cmd.op == OP_DIV_T) || (i_cmd.op == OP_DIV_H);

    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_MUL_V, OP_MUL_T: r_prod <= prod;
            OP_SAT_V: r_x  <= sat_v(r_dvd, r_dneg);
            OP_SAT_T: r_xc <= sat_v(r_dvd, r_dneg);
            OP_SQ:    r_sq <= 40'(prod);
            OP_PA:    r_acc <= ACC_W'(prod);
            OP_PB:    r_acc <= r_acc + (ACC_W'(prod) <<< 20);
            OP_PC:    r_acc <= r_acc + (ACC_W'(prod) <<< 16);
            OP_PD:    r_acc <= r_acc - (ACC_W'({1'b0, COEF_C}) <<< 32);
            OP_EC: begin
                if (r_acc <= 0)                     r_ec <= '0;
                else if (acc_rnd > ACC_W'(OUT_MAX)) r_ec <= OUT_MAX;
                else                                r_ec <= OUT_W'(acc_rnd);
            end
            OP_TDS: begin
                r_p   <= 34'(prod);
                r_tds <= (prod[2*MUL_W-1:16] > (2*MUL_W-16)'(OUT_MAX))
                         ? OUT_MAX : OUT_W'(prod[2*MUL_W-1:16]);
            end
            OP_SAL: r_sal <= (prod[2*MUL_W-1:16] > (2*MUL_W-16)'(OUT_MAX))
                             ? OUT_MAX : OUT_W'(prod[2*MUL_W-1:16]);
            OP_HARD: begin
                if (i_hdiv == '0)                   r_hard <= (r_p != '0) ? OUT_MAX : '0;
                else if (r_dvd > DVD_W'(OUT_MAX))   r_hard <= OUT_MAX;
                else                                r_hard <= OUT_W'(r_dvd);
            end
            default: ;
        endcase
    end

    // restoring divider, one quotient bit per cycle; quotient lands in r_dvd
    assign trial = {r_rem[DSR_W-1:0], r_dvd[DVD_W-1]};
    assign diff  = trial - {1'b0, r_dsr};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbusy <= 1'b0;
        end else if (div_start) begin
            r_dbusy <= 1'b1;
        end else if (r_dbusy && r_dcnt == 6'(DVD_W - 1)) begin
            r_dbusy <= 1'b0;
        end
        if (div_start) begin
            r_rem  <= '0;
            r_dcnt <= '0;
            case (i_cmd.op)
                OP_DIV_T: begin
                    r_dvd <= prod_mag; r_dneg <= r_prod[2*MUL_W-1]; r_dsr <= temp_dsr;
                end
                default: begin
                    r_dvd <= DVD_W'(r_p); r_dneg <= 1'b0; r_dsr <= {i_hdiv, 8'h00};
                end
            endcase
        end else if (i_cmd.op == OP_DIV_V) begin
            r_dvd  <= DVD_W'(v_qprod >> RSH);
            r_dneg <= r_prod[2*MUL_W-1];
        end else if (r_dbusy) begin
            r_dcnt <= r_dcnt + 1'b1;
            if (!diff[DSR_W]) begin
                r_rem <= diff;
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b1};
            end else begin
                r_rem <= trial;
                r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.op == OP_OUT) begin
            r_ovalid <= 1'b1;
        end else if (i_m_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.op == OP_OUT) r_odata <= {4'h0, r_hard, r_sal, r_tds, r_ec};
    end

    assign o_m_valid         = r_ovalid;
    assign o_m_data          = r_odata;
    assign o_status.out_full = r_ovalid && !i_m_ready;
    assign o_status.div_busy = r_dbusy;

endmodule

// File: sim/tb_top.sv
// testbench for trimmed_mean_conductivity_converter: random and directed requests,
// results checked against a built-in predictor of the window, trim, ec, tds, salinity and hardness math
// depends on tmcc_pkg and the rtl of trimmed_mean_conductivity_converter
`timescale 1ns / 1ps

class ec_scoreboard;
    logic signed [15:0] window_q[32];
    int unsigned        wr_pos;
    logic [23:0]        vpb;
    logic [15:0]        tds_f;
    logic [15:0]        sal_f;
    logic [15:0]        hard_div;
    logic [67:0]        pending_q[$];
    int                 mismatches;

    function new();
        foreach (window_q[i]) window_q[i] = '0;
        wr_pos     = 0;
        vpb        = tmcc_pkg::VPB_RST;
        tds_f      = tmcc_pkg::TDSF_RST;
        sal_f      = tmcc_pkg::SALF_RST;
        hard_div   = tmcc_pkg::HDIV_RST;
        mismatches = 0;
    endfunction

    function void set_reg(tmcc_pkg::t_reg idx, logic [31:0] val);
        case (idx)
            tmcc_pkg::REG_VPB:  vpb      = val[23:0];
            tmcc_pkg::REG_TDSF: tds_f    = val[15:0];
            tmcc_pkg::REG_SALF: sal_f    = val[15:0];
            tmcc_pkg::REG_HDIV: hard_div = val[15:0];
            default: ;
        endcase
    endfunction

    function longint sat_volt(longint v);
        if (v > 524287) return 524287;
        if (v < -524288) return -524288;
        return v;
    endfunction

    function longint unsigned sat_out(longint unsigned v);
        return (v > 131071) ? 131071 : v;
    endfunction

    // store sample, predict one result
    function void note_request(logic signed [15:0] adc, logic signed [11:0] temp);
        longint            sorted[32];
        longint            tmp, sum, volt, den, vc, acc;
        longint unsigned   ec, prod, tds, sal, hard;
        int                j;
        window_q[wr_pos] = adc;
        wr_pos = (wr_pos == 31) ? 0 : wr_pos + 1;
        foreach (window_q[i]) sorted[i] = window_q[i];
        for (int i = 1; i < 32; i++) begin
            tmp = sorted[i];
            j = i;
            while (j > 0 && sorted[j-1] > tmp) begin
                sorted[j] = sorted[j-1];
                j--;
            end
            sorted[j] = tmp;
        end
        sum = 0;
        for (int i = 5; i < 27; i++) sum += sorted[i];
        volt = sat_volt((sum * longint'(vpb)) / (longint'(22) * 65536));
        den = longint'(temp) + 400;
        if (den < 1) den = 1;
        vc = sat_volt((volt * 800) / den);
        acc = 64'sd4835705 * (vc * vc) + 64'sd39863583 * vc * 65536
              - 64'sd887030 * (64'sd1 <<< 32);
        ec = 0;
        if (acc > 0) ec = sat_out((longint'(acc) + (64'd1 << 43)) >> 44);
        prod = ec * tds_f;
        tds = sat_out(prod >> 16);
        sal = sat_out((ec * sal_f) >> 16);
        if (hard_div == 0) hard = (prod != 0) ? 131071 : 0;
        else hard = sat_out(prod / (longint'(hard_div) * 256));
        pending_q.push_back({hard[16:0], sal[16:0], tds[16:0], ec[16:0]});
    endfunction

    function void check_result(logic [71:0] got);
        logic [67:0] exp_r;
        if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %h", got);
            return;
        end
        exp_r = pending_q.pop_front();
        if (got[67:0] !== exp_r) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch ec %0d/%0d tds %0d/%0d sal %0d/%0d hard %0d/%0d (exp/got)",
                         exp_r[16:0], got[16:0], exp_r[33:17], got[33:17],
                         exp_r[50:34], got[50:34], exp_r[67:51], got[67:51]);
        end
    endfunction
endclass

module tb_top;
    import tmcc_pkg::*;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;   // adc_sample[15:0], temperature[27:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic [71:0] m_axis_tdata;        // conductivity, dissolved_solids, salinity, hardness
    logic        psel = 0, penable = 0, pwrite = 0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    ec_scoreboard sb = new();
    bit           idle_on = 1;
    bit           hold_sink = 0;
    longint       cycles = 0;

    trimmed_mean_conductivity_converter u_dut (
        .i_clk, .i_rst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
        .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // watchdog for the 585 requests plus stalls
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 4000000) begin
            $display("FAIL trimmed_mean_conductivity_converter");
            $finish;
        end
    end

    task automatic write_reg(t_reg idx, logic [31:0] val);
        psel <= 1; penable <= 0; pwrite <= 1;
        paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        sb.set_reg(idx, val);
        psel <= 0; penable <= 0; pwrite <= 0;
        @(posedge i_clk);
    endtask

    // valid stays up between back-to-back requests; idling or drain drops it
    task automatic send(logic signed [15:0] adc, logic signed [11:0] temp);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1;
        s_axis_tdata  <= {4'b0, temp, adc};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(adc, temp);
    endtask

    task automatic drain();
        s_axis_tvalid <= 0;
        while (sb.pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    function automatic logic signed [11:0] rand_temp();
        case ($urandom_range(0, 5))
            0: return -12'sd320;
            1: return 12'sd2000;
            2: return 12'($urandom_range(0, 100)) - 12'sd420;
            default: return 12'($urandom_range(0, 2320)) - 12'sd320;
        endcase
    endfunction

    function automatic logic signed [15:0] rand_adc(int mode);
        case (mode)
            0: return 16'($urandom);
            1: return 16'($urandom_range(0, 3000));
            default: return 16'($urandom_range(20000, 32767));
        endcase
    endfunction

    // sink: random stalls, checks each result
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
    end

    initial begin
        int stall;
        forever begin
            @(posedge i_clk);
            if (hold_sink) begin
                m_axis_tready <= 0;
                stall = 0;
                while (stall < 4000) begin
                    @(posedge i_clk);
                    stall++;
                end
                hold_sink = 0;
                m_axis_tready <= 1;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
                m_axis_tready <= 1;
            end else begin
                m_axis_tready <= 1;
            end
        end
    end

    initial begin
        int mode;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: reset values, field extremes, cold and negative cases
        send(16'sh7FFF, 12'sd2000);
        send(-16'sh8000, -12'sd320);
        send(16'sd0, 12'sd400);
        send(16'sh7FFF, -12'sd400);
        send(16'sh7FFF, -12'sd401);
        send(16'sh5555, 12'sh555);
        send(-16'sd1, -12'sd1);
        for (int i = 0; i < 14; i++) send(16'sh7FFF, 12'sd0);
        drain();
        write_reg(REG_VPB, 32'hFFFFFF);
        write_reg(REG_TDSF, 32'hFFFF);
        write_reg(REG_SALF, 32'hFFFF);
        write_reg(REG_HDIV, 32'd0);
        send(16'sh7FFF, 12'sd0);
        send(-16'sh8000, 12'sd100);
        drain();
        write_reg(REG_VPB, 32'd1);
        write_reg(REG_TDSF, 32'd0);
        write_reg(REG_SALF, 32'd0);
        write_reg(REG_HDIV, 32'd1);
        send(16'sh7FFF, 12'sd0);
        send(16'sh1234, 12'sd50);
        drain();

        // random phases with varied settings; long receiver hold once
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(REG_VPB, (ph == 7) ? 32'd805306 : 32'($urandom_range(1, 24'hFFFFFF)));
            write_reg(REG_TDSF, 32'($urandom_range(0, 16'hFFFF)));
            write_reg(REG_SALF, 32'($urandom_range(0, 16'hFFFF)));
            write_reg(REG_HDIV, (ph == 3) ? 32'd0 : 32'($urandom_range(1, 16'hFFFF)));
            if (ph == 6) idle_on = 0;
            if (ph == 2) hold_sink = 1;
            mode = ph % 3;
            for (int k = 0; k < 70; k++) send(rand_adc(mode), rand_temp());
            drain();
        end
        while (hold_sink) @(posedge i_clk);
        drain();
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("PASS trimmed_mean_conductivity_converter");
        end else begin
            $display("FAIL trimmed_mean_conductivity_converter");
        end
        $finish;
    end
endmodule
